// ===== rtl/core/meq_pkg.sv =====
`default_nettype none
package meq_pkg;

    localparam int TIME_W     = 32;
    localparam int GEST_W     = 4;
    localparam int CONF_W     = 8;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;
    localparam int MAX_EVENTS = 3;
    localparam int EV_CNT_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENTS_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_HOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_GAP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GEST_GAP   = 3'd5;

    localparam logic [HOLD_W-1:0] START_HOLD_RST = 16'd120;
    localparam logic [HOLD_W-1:0] END_HOLD_RST   = 16'd180;
    localparam logic [HOLD_W-1:0] EVENT_GAP_RST  = 16'd100;
    localparam logic [HOLD_W-1:0] GEST_GAP_RST   = 16'd120;

    typedef enum logic [1:0] {
        EV_GESTURE = 2'd0,
        EV_START   = 2'd1,
        EV_END     = 2'd2,
        EV_SHAKE   = 2'd3
    } ev_kind_t;

    typedef struct packed {
        logic              motion_enabled;
        logic              events_enabled;
        logic [HOLD_W-1:0] start_hold_ms;
        logic [HOLD_W-1:0] end_hold_ms;
        logic [HOLD_W-1:0] event_gap_ms;
        logic [HOLD_W-1:0] gesture_gap_ms;
    } cfg_t;

    typedef struct packed {
        ev_kind_t          kind;
        logic [TIME_W-1:0] event_time;
        logic [GEST_W-1:0] gesture;
        logic [CONF_W-1:0] confidence;
        logic [TIME_W-1:0] gesture_time;
    } event_t;

endpackage
`default_nettype wire

// ===== rtl/core/meq_cfg_regs.sv =====
`default_nettype none
module meq_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [meq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [meq_pkg::HOLD_W-1:0]     cfg_wdata,
    output meq_pkg::cfg_t                       cfg
);
    import meq_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.motion_enabled <= 1'b0;
            cfg_reg.events_enabled <= 1'b0;
            cfg_reg.start_hold_ms  <= START_HOLD_RST;
            cfg_reg.end_hold_ms    <= END_HOLD_RST;
            cfg_reg.event_gap_ms   <= EVENT_GAP_RST;
            cfg_reg.gesture_gap_ms <= GEST_GAP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MOTION_EN:  cfg_reg.motion_enabled <= cfg_wdata[0];
                CFG_EVENTS_EN:  cfg_reg.events_enabled <= cfg_wdata[0];
                CFG_START_HOLD: cfg_reg.start_hold_ms  <= cfg_wdata;
                CFG_END_HOLD:   cfg_reg.end_hold_ms    <= cfg_wdata;
                CFG_EVENT_GAP:  cfg_reg.event_gap_ms   <= cfg_wdata;
                CFG_GEST_GAP:   cfg_reg.gesture_gap_ms <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/core/meq_core.sv =====
`default_nettype none
module meq_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire meq_pkg::cfg_t                  cfg,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [meq_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                           buf_free,
    output logic                                load,
    output meq_pkg::event_t                     ev [meq_pkg::MAX_EVENTS],
    output logic [meq_pkg::EV_CNT_W-1:0]        ev_cnt
);
    import meq_pkg::*;

    logic                 in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;

    logic              active_reg, active_next;
    logic [TIME_W-1:0] motion_since_reg, motion_since_next;
    logic              msv_reg, msv_next;
    logic [TIME_W-1:0] still_since_reg, still_since_next;
    logic              ssv_reg, ssv_next;
    logic              shake_reg;
    logic [TIME_W-1:0] last_sent_reg, last_sent_next;
    logic [GEST_W-1:0] held_gest_reg, held_gest_next;
    logic [CONF_W-1:0] held_conf_reg, held_conf_next;
    logic [TIME_W-1:0] held_time_reg, held_time_next;

    logic [TIME_W-1:0] now;
    logic              moving, shaking, present;
    logic [GEST_W-1:0] kind;
    logic [CONF_W-1:0] strength;

    logic [TIME_W-1:0] d_last, ms_eff, ss_eff, d_ms, d_ss;
    logic              gap0, gap1, gap2, gap_zero, g_valid, try_g, try_m, try_s;
    logic              sent_g, sent_m, sent_s;
    ev_kind_t          m_kind;
    event_t            ev_g, ev_m, ev_s;

    assign load     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || buf_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    assign now      = in_data_reg[31:0];
    assign moving   = in_data_reg[32];
    assign shaking  = in_data_reg[33];
    assign present  = in_data_reg[34];
    assign kind     = in_data_reg[38:35];
    assign strength = in_data_reg[46:39];

    always_comb begin
        d_last   = now - last_sent_reg;
        gap_zero = (cfg.event_gap_ms == '0);
        gap0     = d_last >= {{(TIME_W-HOLD_W){1'b0}}, cfg.event_gap_ms};
        g_valid  = present && (kind != '0) && (strength != '0);
        try_g    = g_valid && (kind != held_gest_reg) &&
                   (d_last >= {{(TIME_W-HOLD_W){1'b0}}, cfg.gesture_gap_ms});
        sent_g   = try_g && cfg.events_enabled && gap0;
        gap1     = sent_g ? gap_zero : gap0;

        ms_eff = msv_reg ? motion_since_reg : now;
        ss_eff = ssv_reg ? still_since_reg : now;
        d_ms   = now - ms_eff;
        d_ss   = now - ss_eff;

        active_next       = active_reg;
        motion_since_next = motion_since_reg;
        msv_next          = 1'b0;
        still_since_next  = still_since_reg;
        ssv_next          = 1'b0;
        try_m             = 1'b0;
        m_kind            = EV_START;
        if (moving) begin
            if (!active_reg) begin
                if (d_ms >= {{(TIME_W-HOLD_W){1'b0}}, cfg.start_hold_ms}) begin
                    try_m       = 1'b1;
                    active_next = 1'b1;
                end else begin
                    motion_since_next = ms_eff;
                    msv_next          = 1'b1;
                end
            end
        end else begin
            if (active_reg) begin
                m_kind = EV_END;
                if (d_ss >= {{(TIME_W-HOLD_W){1'b0}}, cfg.end_hold_ms}) begin
                    try_m       = 1'b1;
                    active_next = 1'b0;
                end else begin
                    still_since_next = ss_eff;
                    ssv_next         = 1'b1;
                end
            end
        end
        sent_m = try_m && cfg.events_enabled && gap1;
        gap2   = sent_m ? gap_zero : gap1;

        try_s  = shaking && !shake_reg;
        sent_s = try_s && cfg.events_enabled && gap2;

        last_sent_next = (sent_g || sent_m || sent_s) ? now : last_sent_reg;
        held_gest_next = g_valid ? kind : held_gest_reg;
        held_conf_next = g_valid ? strength : held_conf_reg;
        held_time_next = g_valid ? now : held_time_reg;
    end

    always_comb begin
        ev_g = '{kind: EV_GESTURE, event_time: now, gesture: kind,
                 confidence: strength, gesture_time: now};
        ev_m = '{kind: m_kind, event_time: now, gesture: '0,
                 confidence: '0, gesture_time: '0};
        ev_s = '{kind: EV_SHAKE, event_time: now, gesture: '0,
                 confidence: '0, gesture_time: '0};
        ev[0] = sent_g ? ev_g : (sent_m ? ev_m : ev_s);
        ev[1] = (sent_g && sent_m) ? ev_m : ev_s;
        ev[2] = ev_s;
        if (cfg.motion_enabled) begin
            ev_cnt = EV_CNT_W'({1'b0, sent_g} + {1'b0, sent_m} + {1'b0, sent_s});
        end else begin
            ev_cnt = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg       <= 1'b0;
            motion_since_reg <= '0;
            msv_reg          <= 1'b0;
            still_since_reg  <= '0;
            ssv_reg          <= 1'b0;
            shake_reg        <= 1'b0;
            last_sent_reg    <= '0;
            held_gest_reg    <= '0;
            held_conf_reg    <= '0;
            held_time_reg    <= '0;
        end else if (load && cfg.motion_enabled) begin
            active_reg       <= active_next;
            motion_since_reg <= motion_since_next;
            msv_reg          <= msv_next;
            still_since_reg  <= still_since_next;
            ssv_reg          <= ssv_next;
            shake_reg        <= shaking;
            last_sent_reg    <= last_sent_next;
            held_gest_reg    <= held_gest_next;
            held_conf_reg    <= held_conf_next;
            held_time_reg    <= held_time_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/meq_event_buf.sv =====
`default_nettype none
module meq_event_buf (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            load,
    input  wire meq_pkg::event_t                 ev [meq_pkg::MAX_EVENTS],
    input  wire logic [meq_pkg::EV_CNT_W-1:0]    ev_cnt,
    output logic                                 buf_free,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [meq_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast
);
    import meq_pkg::*;

    event_t              slot_reg [MAX_EVENTS];
    logic [EV_CNT_W-1:0] cnt_reg;
    logic                pop;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == EV_CNT_W'(1));
    assign pop      = m_tvalid && m_tready;
    assign buf_free = (cnt_reg == '0) || (m_tlast && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= ev_cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - EV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= ev;
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    assign m_tuser = slot_reg[0].kind;
    assign m_tdata = {4'b0, slot_reg[0].gesture_time, slot_reg[0].confidence,
                      slot_reg[0].gesture, slot_reg[0].event_time};

endmodule
`default_nettype wire

// ===== rtl/core/motion_event_qualifier.sv =====
`default_nettype none
// Channel   Dir  Ports                      Contents
// s_ (in)   in   tvalid tready tdata[47:0]  one detector frame per word
// m_ (out)  out  tvalid tready tdata[79:0]  one event per word, kind in tuser,
//                tuser[1:0] tlast           tlast on the final event of a frame
// cfg       in   cfg_we cfg_index cfg_wdata register writes, no read-back
//
// A frame is registered and qualified from that register; its 0 to 3 events are
// loaded into a three-slot output buffer that drains one word per cycle while
// m_tready is high. Throughput: one frame per cycle while m_tready is high and
// frames cause at most one event, else the input waits on the single output port.
// Reset (aresetn low, synchronous) clears tracking state and buffer; presets cfg.
// Backpressure on m_ stalls the input register once the buffer is still busy.
module motion_event_qualifier (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [meq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [meq_pkg::HOLD_W-1:0]     cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // now_ms[31:0], motion_seen[32], shake_seen[33], gesture_present[34],
    // gesture_kind[38:35], gesture_strength[46:39], zero[47]
    input  wire logic [meq_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // event_time[31:0], event_gesture[35:32], event_confidence[43:36],
    // event_gesture_time[75:44], zero[79:76]
    output logic [meq_pkg::OUT_DATA_W-1:0]      m_tdata,
    // event_kind[1:0]
    output logic [1:0]                          m_tuser,
    // last_of_run
    output logic                                m_tlast
);
    import meq_pkg::*;

    cfg_t                cfg;
    logic                buf_free;
    logic                load;
    event_t              ev [MAX_EVENTS];
    logic [EV_CNT_W-1:0] ev_cnt;

    meq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    meq_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .buf_free (buf_free),
        .load     (load),
        .ev       (ev),
        .ev_cnt   (ev_cnt)
    );

    meq_event_buf u_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .ev       (ev),
        .ev_cnt   (ev_cnt),
        .buf_free (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
